// ===== hdl/jhd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package jhd_pkg;

  localparam int ENTRIES_DEF     = 256;
  localparam int TABLE_SLOTS_DEF = 2;
  localparam int COMPONENTS_DEF  = 3;

  localparam int MAX_CODE_LEN = 16;
  localparam int BLOCK_LEN    = 64;
  localparam int WORD_W       = 29;

  localparam logic [7:0] SYM_EOB  = 8'h00;
  localparam logic [7:0] MAG_MASK = 8'h0F;

  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_START = 2'd1;
  localparam logic [1:0] MODE_BIT   = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_DC_CODE,
    PH_DC_EXTRA,
    PH_AC_CODE,
    PH_AC_EXTRA
  } phase_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_t;

endpackage

`default_nettype wire

// ===== hdl/jhd_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module jhd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hdl/jpeg_huffman_block_decoder.sv =====
// channel | direction | handshake           | payload
// in      | input     | in_valid / in_stall  | mode, entry fields, start fields, stream bit
// out     | output    | out_valid / out_stall| coef_index, coef_value, has_coef, block_end, code_error
//
// after reset the code store is cleared, every entry of it, with in_stall held high
// table writes, starts and extra bits are taken without a scan; a code bit scans the selected
// table in the code store, one entry a cycle, until a hit or the last entry
// an item with a result passes through the ST_EMIT state into the output register
// out_stall holds the output register; the next item is taken while a result waits there, not in ST_EMIT
`timescale 1ns / 1ps
`default_nettype none

module jpeg_huffman_block_decoder #(
  parameter int ENTRIES     = jhd_pkg::ENTRIES_DEF,
  parameter int TABLE_SLOTS = jhd_pkg::TABLE_SLOTS_DEF,
  parameter int COMPONENTS  = jhd_pkg::COMPONENTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_mode,
  input  wire logic        in_entry_is_ac,
  input  wire logic        in_entry_table,
  input  wire logic [7:0]  in_entry_slot,
  input  wire logic [4:0]  in_entry_length,
  input  wire logic [15:0] in_entry_code,
  input  wire logic [7:0]  in_entry_symbol,
  input  wire logic [1:0]  in_component,
  input  wire logic        in_dc_table,
  input  wire logic        in_ac_table,
  input  wire logic        in_stream_bit,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [5:0]       out_coef_index,
  output logic signed [15:0] out_coef_value,
  output logic             out_has_coef,
  output logic             out_block_end,
  output logic             out_code_error
);

  import jhd_pkg::*;

  localparam int DEPTH  = 2 * TABLE_SLOTS * ENTRIES;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int TAB_W  = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int COMP_W = (COMPONENTS > 1) ? $clog2(COMPONENTS) : 1;

  function automatic logic [15:0] extend_val(input logic [3:0] m, input logic [15:0] v);
    logic [15:0] half;
    logic [15:0] full;
    half = 16'h1 << (m - 4'd1);
    full = 16'h1 << m;
    if (v < half) begin
      extend_val = v + 16'd1 - full;
    end else begin
      extend_val = v;
    end
  endfunction

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;

  logic [15:0]       bits_r, bits_nxt;
  logic [4:0]        cnt_r, cnt_nxt;
  logic [3:0]        mag_r, mag_nxt;
  logic [3:0]        left_r, left_nxt;
  logic [15:0]       extra_r, extra_nxt;
  logic [3:0]        run_r, run_nxt;
  logic [6:0]        pos_r, pos_nxt;
  logic [COMP_W-1:0] comp_r, comp_nxt;
  logic [TAB_W-1:0]  dcs_r, dcs_nxt;
  logic [TAB_W-1:0]  acs_r, acs_nxt;
  logic [15:0]       pred_r [COMPONENTS];
  logic [15:0]       pred_new;
  logic              pred_we;

  logic [5:0]  pidx_r, pidx_nxt;
  logic [15:0] pval_r, pval_nxt;
  logic        phas_r, phas_nxt;
  logic        pend_r, pend_nxt;
  logic        perr_r, perr_nxt;

  logic [ADDR_W-1:0] clr_r;
  logic [IDX_W-1:0]  sidx_r, sidx_nxt;
  logic              issue_r, issue_nxt;
  logic              chk_r, chk_nxt;
  logic              last_r, last_nxt;

  logic              in_acc;
  logic              emit_go;
  logic              scan_done;
  logic              out_free;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  logic [WORD_W-1:0] mem_rdata;
  logic              hit;
  logic [15:0]       mask;
  logic              scan_ac;
  logic [TAB_W-1:0]  scan_tab;
  logic              wr_ok;

  jhd_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign scan_ac  = (phase_r == PH_AC_CODE);
  assign scan_tab = scan_ac ? acs_r : dcs_r;
  assign mask     = 16'((17'h1 << cnt_r) - 17'h1);
  assign hit      = chk_r && (mem_rdata[28:24] == cnt_r)
                    && ((mem_rdata[23:8] & mask) == (bits_r & mask));
  assign scan_done = chk_r && (hit || last_r);
  assign wr_ok    = (32'(in_entry_table) < TABLE_SLOTS) && (32'(in_entry_slot) < ENTRIES);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (32'(clr_r) == DEPTH - 1) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc && in_mode == MODE_BIT
            && (phase_r == PH_DC_CODE || phase_r == PH_AC_CODE)) begin
          state_nxt = ST_SCAN;
        end else if (emit_go) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_SCAN: begin
        if (scan_done) state_nxt = emit_go ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall  = 1'b1;
    mem_we    = 1'b0;
    mem_waddr = clr_r;
    mem_wdata = '0;
    mem_raddr = ADDR_W'(32'(scan_ac) * TABLE_SLOTS * ENTRIES
                        + 32'(scan_tab) * ENTRIES + 32'(sidx_r));
    unique case (state_r)
      ST_CLEAR: begin
        mem_we = 1'b1;
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid && in_mode == MODE_WRITE && wr_ok) begin
          mem_we    = 1'b1;
          mem_waddr = ADDR_W'(32'(in_entry_is_ac) * TABLE_SLOTS * ENTRIES
                              + 32'(in_entry_table) * ENTRIES + 32'(in_entry_slot));
          mem_wdata = {in_entry_length, in_entry_code, in_entry_symbol};
        end
      end
      ST_SCAN: ;
      ST_EMIT: ;
      default: ;
    endcase
  end

  // datapath
  always_comb begin
    logic        do_dc;
    logic        do_ac;
    logic        rep;
    logic [15:0] fval;
    logic [15:0] nextra;
    logic [7:0]  sym;
    logic [6:0]  p;
    logic [6:0]  p1;

    do_dc = 1'b0;
    do_ac = 1'b0;
    rep   = 1'b0;
    fval  = '0;
    nextra = {extra_r[14:0], in_stream_bit};
    sym   = mem_rdata[7:0];
    p     = '0;
    p1    = '0;

    phase_nxt = phase_r;
    bits_nxt  = bits_r;
    cnt_nxt   = cnt_r;
    mag_nxt   = mag_r;
    left_nxt  = left_r;
    extra_nxt = extra_r;
    run_nxt   = run_r;
    pos_nxt   = pos_r;
    comp_nxt  = comp_r;
    dcs_nxt   = dcs_r;
    acs_nxt   = acs_r;
    pred_we   = 1'b0;
    pred_new  = pred_r[comp_r] + fval;
    emit_go   = 1'b0;
    pidx_nxt  = pidx_r;
    pval_nxt  = pval_r;
    phas_nxt  = phas_r;
    pend_nxt  = pend_r;
    perr_nxt  = perr_r;
    sidx_nxt  = sidx_r;
    issue_nxt = issue_r;
    chk_nxt   = chk_r;
    last_nxt  = last_r;

    if (state_r == ST_IDLE && in_acc) begin
      if (in_mode == MODE_START) begin
        comp_nxt  = (32'(in_component) < COMPONENTS) ? COMP_W'(in_component)
                                                    : COMP_W'(COMPONENTS - 1);
        dcs_nxt   = (32'(in_dc_table) < TABLE_SLOTS) ? TAB_W'(in_dc_table)
                                                    : TAB_W'(TABLE_SLOTS - 1);
        acs_nxt   = (32'(in_ac_table) < TABLE_SLOTS) ? TAB_W'(in_ac_table)
                                                    : TAB_W'(TABLE_SLOTS - 1);
        bits_nxt  = '0;
        cnt_nxt   = '0;
        mag_nxt   = '0;
        left_nxt  = '0;
        extra_nxt = '0;
        run_nxt   = '0;
        pos_nxt   = '0;
        phase_nxt = PH_DC_CODE;
      end else if (in_mode == MODE_BIT) begin
        if (phase_r == PH_DC_EXTRA || phase_r == PH_AC_EXTRA) begin
          extra_nxt = nextra;
          left_nxt  = left_r - 4'd1;
          if (left_r == 4'd1) begin
            fval = extend_val(mag_r, nextra);
            if (phase_r == PH_DC_EXTRA) begin
              do_dc = 1'b1;
            end else begin
              do_ac = 1'b1;
              rep   = 1'b1;
            end
          end
        end else if (phase_r == PH_DC_CODE || phase_r == PH_AC_CODE) begin
          bits_nxt  = {bits_r[14:0], in_stream_bit};
          cnt_nxt   = cnt_r + 5'd1;
          sidx_nxt  = '0;
          issue_nxt = 1'b1;
          chk_nxt   = 1'b0;
          last_nxt  = 1'b0;
        end
      end
    end

    if (state_r == ST_SCAN) begin
      if (issue_r) begin
        sidx_nxt  = IDX_W'(32'(sidx_r) + 1);
        issue_nxt = (32'(sidx_r) != ENTRIES - 1);
        last_nxt  = (32'(sidx_r) == ENTRIES - 1);
      end
      chk_nxt = issue_r;
      if (scan_done) begin
        issue_nxt = 1'b0;
        chk_nxt   = 1'b0;
        if (hit) begin
          bits_nxt  = '0;
          cnt_nxt   = '0;
          extra_nxt = '0;
          if (!scan_ac) begin
            mag_nxt = sym[3:0];
            if (sym[3:0] == 4'd0) begin
              do_dc = 1'b1;
            end else begin
              left_nxt  = sym[3:0];
              phase_nxt = PH_DC_EXTRA;
            end
          end else if (sym == SYM_EOB) begin
            phase_nxt = PH_IDLE;
            emit_go   = 1'b1;
            phas_nxt  = 1'b0;
            pend_nxt  = 1'b1;
            perr_nxt  = 1'b0;
          end else begin
            run_nxt = sym[7:4];
            mag_nxt = 4'(sym & MAG_MASK);
            if ((sym & MAG_MASK) == 8'd0) begin
              do_ac = 1'b1;
            end else begin
              left_nxt  = 4'(sym & MAG_MASK);
              phase_nxt = PH_AC_EXTRA;
            end
          end
        end else if (32'(cnt_r) >= MAX_CODE_LEN) begin
          phase_nxt = PH_IDLE;
          bits_nxt  = '0;
          cnt_nxt   = '0;
          emit_go   = 1'b1;
          phas_nxt  = 1'b0;
          pend_nxt  = 1'b1;
          perr_nxt  = 1'b1;
        end
      end
    end

    pred_new = pred_r[comp_r] + fval;

    if (do_dc) begin
      pred_we   = 1'b1;
      pos_nxt   = 7'd1;
      phase_nxt = PH_AC_CODE;
      emit_go   = 1'b1;
      pidx_nxt  = '0;
      pval_nxt  = pred_new;
      phas_nxt  = 1'b1;
      pend_nxt  = 1'b0;
      perr_nxt  = 1'b0;
    end

    if (do_ac) begin
      p  = pos_r + {3'd0, run_nxt};
      p1 = p + 7'd1;
      pidx_nxt = p[5:0];
      pval_nxt = fval;
      perr_nxt = 1'b0;
      if (32'(p) >= BLOCK_LEN) begin
        phase_nxt = PH_IDLE;
        emit_go   = 1'b1;
        phas_nxt  = 1'b0;
        pend_nxt  = 1'b1;
      end else if (32'(p1) >= BLOCK_LEN) begin
        pos_nxt   = p1;
        phase_nxt = PH_IDLE;
        emit_go   = 1'b1;
        phas_nxt  = rep;
        pend_nxt  = 1'b1;
      end else begin
        pos_nxt   = p1;
        phase_nxt = PH_AC_CODE;
        emit_go   = rep;
        phas_nxt  = 1'b1;
        pend_nxt  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      phase_r <= PH_IDLE;
      clr_r   <= '0;
      issue_r <= 1'b0;
      chk_r   <= 1'b0;
      last_r  <= 1'b0;
      bits_r  <= '0;
      cnt_r   <= '0;
      mag_r   <= '0;
      left_r  <= '0;
      extra_r <= '0;
      run_r   <= '0;
      pos_r   <= '0;
      comp_r  <= '0;
      dcs_r   <= '0;
      acs_r   <= '0;
      for (int i = 0; i < COMPONENTS; i++) begin
        pred_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      if (state_r == ST_CLEAR) clr_r <= ADDR_W'(32'(clr_r) + 1);
      issue_r <= issue_nxt;
      chk_r   <= chk_nxt;
      last_r  <= last_nxt;
      bits_r  <= bits_nxt;
      cnt_r   <= cnt_nxt;
      mag_r   <= mag_nxt;
      left_r  <= left_nxt;
      extra_r <= extra_nxt;
      run_r   <= run_nxt;
      pos_r   <= pos_nxt;
      comp_r  <= comp_nxt;
      dcs_r   <= dcs_nxt;
      acs_r   <= acs_nxt;
      if (pred_we) pred_r[comp_r] <= pred_new;
    end
  end

  always_ff @(posedge clk) begin
    sidx_r <= sidx_nxt;
    pidx_r <= pidx_nxt;
    pval_r <= pval_nxt;
    phas_r <= phas_nxt;
    pend_r <= pend_nxt;
    perr_r <= perr_nxt;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (state_r == ST_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_EMIT && out_free) begin
      out_coef_index <= phas_r ? pidx_r : 6'd0;
      out_coef_value <= phas_r ? pval_r : 16'd0;
      out_has_coef   <= phas_r;
      out_block_end  <= pend_r;
      out_code_error <= perr_r;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/jhd_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module jhd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [5:0]  out_coef_index,
  input wire logic [15:0] out_coef_value,
  input wire logic        out_has_coef,
  input wire logic        out_block_end,
  input wire logic        out_code_error
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_coef_value)
      && $stable(out_block_end))
    else $error("stalled item changed");

  a_no_coef_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_coef |-> out_coef_index == 6'd0 && out_coef_value == 16'd0)
    else $error("empty item carries coefficient bits");

  a_error_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_code_error |-> out_block_end && !out_has_coef)
    else $error("code error without block end");

  a_item_meaning: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_has_coef || out_block_end)
    else $error("item with nothing in it");

endmodule

bind jpeg_huffman_block_decoder jhd_checker u_jhd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_coef_index (out_coef_index),
  .out_coef_value (out_coef_value),
  .out_has_coef   (out_has_coef),
  .out_block_end  (out_block_end),
  .out_code_error (out_code_error)
);

`default_nettype wire

// ===== test/jpeg_huffman_block_decoder_test.sv =====
`timescale 1ns / 1ps

module jpeg_huffman_block_decoder_test;
  import jhd_pkg::*;

  localparam int NENT = 256;
  localparam int NTAB = 2;
  localparam int NCOMP = 3;
  localparam logic [1:0] MODE_NONE = 2'd3;

  typedef struct packed {
    logic [5:0] index;
    logic [15:0] value;
    logic has;
    logic last;
    logic err;
  } coef_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic [1:0] in_mode = MODE_WRITE;
  logic in_entry_is_ac = 0;
  logic in_entry_table = 0;
  logic [7:0] in_entry_slot = 0;
  logic [4:0] in_entry_length = 0;
  logic [15:0] in_entry_code = 0;
  logic [7:0] in_entry_symbol = 0;
  logic [1:0] in_component = 0;
  logic in_dc_table = 0;
  logic in_ac_table = 0;
  logic in_stream_bit = 0;
  logic out_valid;
  logic out_stall = 0;
  logic [5:0] out_coef_index;
  logic signed [15:0] out_coef_value;
  logic out_has_coef;
  logic out_block_end;
  logic out_code_error;

  jpeg_huffman_block_decoder dut (.*);

  always #5 clk = ~clk;

  // predictor state
  logic [4:0] tbl_len [2*NTAB*NENT];
  logic [15:0] tbl_code [2*NTAB*NENT];
  logic [7:0] tbl_sym [2*NTAB*NENT];
  logic [15:0] dc_pred [NCOMP];
  logic [15:0] bits_acc;
  int unsigned bit_cnt;
  phase_t ph;
  int unsigned mag, extra_left, run_len, pos, comp, dc_sel, ac_sel;
  logic [15:0] extra_acc;

  coef_t expected_coefs[$];
  int errors = 0;
  bit quiet = 0;
  bit hold_out = 0;

  // shadow of the current test tables, for building valid streams
  logic [4:0] gen_len [2][2][256];
  logic [15:0] gen_code [2][2][256];
  logic [7:0] gen_sym [2][2][256];
  int gen_cnt [2][2];

  function automatic logic [15:0] sign_extend_mag(int unsigned m, logic [15:0] v);
    if (v < (16'd1 << (m - 1))) return v + 16'd1 - (16'd1 << m);
    return v;
  endfunction

  function automatic void push_coef(int unsigned idx, logic [15:0] val, bit has, bit last,
                                    bit err);
    coef_t c;
    c.index = has ? idx[5:0] : 6'd0;
    c.value = has ? val : 16'd0;
    c.has = has;
    c.last = last;
    c.err = err;
    expected_coefs.push_back(c);
  endfunction

  function automatic void place_dc(logic [15:0] diff);
    dc_pred[comp] = dc_pred[comp] + diff;
    pos = 1;
    ph = PH_AC_CODE;
    push_coef(0, dc_pred[comp], 1, 0, 0);
  endfunction

  function automatic void place_ac(logic [15:0] val, bit report);
    int unsigned at;
    pos += run_len;
    if (pos >= 64) begin
      ph = PH_IDLE;
      push_coef(0, 0, 0, 1, 0);
      return;
    end
    at = pos;
    pos++;
    if (pos >= 64) begin
      ph = PH_IDLE;
      push_coef(at, val, report, 1, 0);
      return;
    end
    ph = PH_AC_CODE;
    if (report) push_coef(at, val, 1, 0, 0);
  endfunction

  function automatic void predict(logic [1:0] md, logic cls, logic tb, logic [7:0] sl,
                                  logic [4:0] ln, logic [15:0] cd, logic [7:0] sy,
                                  logic [1:0] cp, logic dt, logic at, logic b);
    int e, base;
    logic [15:0] mask;
    logic [7:0] s;
    bit is_ac;
    if (md == MODE_WRITE) begin
      e = (int'(cls) * NTAB + int'(tb)) * NENT + int'(sl);
      tbl_len[e] = ln;
      tbl_code[e] = cd;
      tbl_sym[e] = sy;
      return;
    end
    if (md == MODE_START) begin
      comp = cp < NCOMP ? cp : NCOMP - 1;
      dc_sel = dt;
      ac_sel = at;
      bits_acc = 0; bit_cnt = 0; mag = 0; extra_left = 0; extra_acc = 0;
      run_len = 0; pos = 0;
      ph = PH_DC_CODE;
      return;
    end
    if (md != MODE_BIT || ph == PH_IDLE) return;
    if (ph == PH_DC_EXTRA || ph == PH_AC_EXTRA) begin
      extra_acc = {extra_acc[14:0], b};
      extra_left--;
      if (extra_left != 0) return;
      if (ph == PH_DC_EXTRA) place_dc(sign_extend_mag(mag, extra_acc));
      else place_ac(sign_extend_mag(mag, extra_acc), 1);
      return;
    end
    bits_acc = {bits_acc[14:0], b};
    bit_cnt++;
    is_ac = (ph == PH_AC_CODE);
    base = ((is_ac ? 1 : 0) * NTAB + (is_ac ? ac_sel : dc_sel)) * NENT;
    mask = 16'((17'd1 << bit_cnt) - 17'd1);
    e = -1;
    for (int i = 0; i < NENT; i++) begin
      if (tbl_len[base+i] == bit_cnt && (tbl_code[base+i] & mask) == (bits_acc & mask)) begin
        e = base + i;
        break;
      end
    end
    if (e < 0) begin
      if (bit_cnt >= 16) begin
        ph = PH_IDLE;
        bits_acc = 0; bit_cnt = 0;
        push_coef(0, 0, 0, 1, 1);
      end
      return;
    end
    s = tbl_sym[e];
    bits_acc = 0; bit_cnt = 0; extra_acc = 0;
    if (!is_ac) begin
      mag = s & MAG_MASK;
      if (mag == 0) place_dc(0);
      else begin
        extra_left = mag;
        ph = PH_DC_EXTRA;
      end
      return;
    end
    if (s == SYM_EOB) begin
      ph = PH_IDLE;
      push_coef(0, 0, 0, 1, 0);
      return;
    end
    run_len = s >> 4;
    mag = s & MAG_MASK;
    if (mag == 0) place_ac(0, 0);
    else begin
      extra_left = mag;
      ph = PH_AC_EXTRA;
    end
  endfunction

  task automatic send_item(logic [1:0] md, logic cls = 0, logic tb = 0, logic [7:0] sl = 0,
                           logic [4:0] ln = 0, logic [15:0] cd = 0, logic [7:0] sy = 0,
                           logic [1:0] cp = 0, logic dt = 0, logic at = 0, logic b = 0);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid = 0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_valid = 1;
    in_mode <= md; in_entry_is_ac <= cls; in_entry_table <= tb; in_entry_slot <= sl;
    in_entry_length <= ln; in_entry_code <= cd; in_entry_symbol <= sy;
    in_component <= cp; in_dc_table <= dt; in_ac_table <= at; in_stream_bit <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict(md, cls, tb, sl, ln, cd, sy, cp, dt, at, b);
    @(negedge clk);
    in_valid = 0;
  endtask

  task automatic write_entry(logic cls, logic tb, logic [7:0] sl, logic [4:0] ln,
                             logic [15:0] cd, logic [7:0] sy);
    gen_len[cls][tb][sl] = ln;
    gen_code[cls][tb][sl] = cd;
    gen_sym[cls][tb][sl] = sy;
    send_item(MODE_WRITE, cls, tb, sl, ln, cd, sy);
  endtask

  task automatic send_bits(logic [15:0] v, int n);
    for (int i = n - 1; i >= 0; i--) send_item(MODE_BIT, .b(v[i]));
  endtask

  // tables: code k of length L is k written in L bits, lengths grow with slot
  task automatic load_tables(int n);
    for (int cls = 0; cls < 2; cls++)
      for (int tb = 0; tb < 2; tb++) begin
        int code, ln;
        code = 0; ln = 2;
        gen_cnt[cls][tb] = n;
        for (int i = 0; i < n; i++) begin
          logic [7:0] sy;
          if (i > 0 && $urandom_range(0, 2) == 0 && ln < 16) begin
            code = code << 1; ln++;
          end
          if (cls == 0) sy = {4'($urandom_range(0, 15)), 4'($urandom_range(0, 15))};
          else if (i == 0) sy = SYM_EOB;
          else if (i == 1) sy = 8'hF0;
          else sy = 8'($urandom_range(1, 255));
          write_entry(cls, tb, i, ln, 16'(code | ($urandom_range(0, 1) << ln)), sy);
          code++;
        end
      end
  endtask

  task automatic send_block(int ac_count);
    logic dt, at;
    int k;
    dt = $urandom_range(0, 1);
    at = $urandom_range(0, 1);
    send_item(MODE_START, .cp($urandom_range(0, 3)), .dt(dt), .at(at));
    k = $urandom_range(0, gen_cnt[0][dt] - 1);
    send_bits(gen_code[0][dt][k], gen_len[0][dt][k]);
    send_bits($urandom, gen_sym[0][dt][k] & MAG_MASK);
    for (int j = 0; j < ac_count && ph != PH_IDLE; j++) begin
      k = (j == ac_count - 1) ? 0 : $urandom_range(1, gen_cnt[1][at] - 1);
      send_bits(gen_code[1][at][k], gen_len[1][at][k]);
      send_bits($urandom, gen_sym[1][at][k] & MAG_MASK);
    end
  endtask

  task automatic drain();
    while (expected_coefs.size() != 0) @(negedge clk);
    repeat (NENT + 10) @(negedge clk);
  endtask

  task automatic test_directed();
    write_entry(0, 0, 0, 1, 16'hFFFE, 8'h00);
    write_entry(0, 0, 1, 2, 16'h0002, 8'hFF);
    write_entry(0, 1, 255, 16, 16'hFFFF, 8'h01);
    write_entry(1, 0, 0, 1, 16'h0000, SYM_EOB);
    write_entry(1, 0, 1, 3, 16'h0004, 8'hF0);
    write_entry(1, 0, 2, 3, 16'h0005, 8'h3F);
    write_entry(1, 0, 3, 3, 16'h0006, 8'h01);
    write_entry(1, 1, 255, 31, 16'h0000, 8'h11);
    send_item(MODE_BIT, .b(1));
    send_item(MODE_NONE);
    send_item(MODE_START, .cp(3));
    send_bits(16'b10, 2); send_bits(16'h7FFF, 15);
    send_bits(16'b100, 3); send_bits(16'b100, 3); send_bits(16'b100, 3);
    send_bits(16'b100, 3);
    send_bits(16'b101, 3); send_bits(16'h0000, 15);
    send_item(MODE_START, .cp(1));
    send_bits(16'b0, 1);
    send_bits(16'b110, 3); send_bits(16'b1, 1);
    send_item(MODE_START, .cp(0), .dt(1), .at(1));
    send_bits(16'hFFFF, 16);
    send_bits(16'h0000, 16);
    send_item(MODE_START, .cp(2));
    send_bits(16'b0, 1);
    for (int i = 0; i < 63; i++) send_bits(16'b1101, 4);
    send_item(MODE_START, .cp(2));
    send_bits(16'b0, 1); send_bits(16'b0, 1);
    drain();
  endtask

  task automatic test_noise();
    repeat (200) begin
      int r;
      r = $urandom_range(0, 19);
      if (r == 0)
        send_item(MODE_WRITE, $urandom, $urandom, $urandom_range(0, 7), $urandom_range(0, 31),
                  $urandom, $urandom);
      else if (r < 3)
        send_item(MODE_START, .cp($urandom), .dt($urandom), .at($urandom));
      else if (r == 3) send_item(MODE_NONE, .b($urandom));
      else send_item(MODE_BIT, .b($urandom));
    end
    drain();
  endtask

  task automatic test_blocks();
    load_tables(8);
    repeat (6) send_block($urandom_range(1, 20));
    drain();
  endtask

  task automatic test_backpressure();
    hold_out = 1;
    repeat (3) send_block(6);
    hold_out = 0;
    drain();
  endtask

  task automatic test_no_idle();
    quiet = 1;
    load_tables(12);
    repeat (5) send_block($urandom_range(1, 40));
    drain();
  endtask

  initial begin : out_idle
    forever begin
      @(negedge clk);
      if (hold_out) out_stall <= 1;
      else if (quiet) out_stall <= 0;
      else if ($urandom_range(0, 5) == 0) begin
        out_stall <= 1;
        repeat ($urandom_range(1, 19)) @(negedge clk);
        out_stall <= 0;
      end else out_stall <= 0;
    end
  end

  initial begin : hold_stretch
    @(posedge hold_out);
    repeat (600) @(negedge clk);
    hold_out = 0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      coef_t exp_c;
      if (expected_coefs.size() == 0) begin
        $error("result with none expected");
        errors++;
      end else begin
        exp_c = expected_coefs.pop_front();
        if (out_has_coef !== exp_c.has) begin
          $error("has_coef expected %0d got %0d", exp_c.has, out_has_coef); errors++;
        end
        if (out_coef_index !== exp_c.index) begin
          $error("coef_index expected %0d got %0d", exp_c.index, out_coef_index); errors++;
        end
        if (out_coef_value !== exp_c.value) begin
          $error("coef_value expected %0d got %0d", $signed(exp_c.value), out_coef_value);
          errors++;
        end
        if (out_block_end !== exp_c.last) begin
          $error("block_end expected %0d got %0d", exp_c.last, out_block_end); errors++;
        end
        if (out_code_error !== exp_c.err) begin
          $error("code_error expected %0d got %0d", exp_c.err, out_code_error); errors++;
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < 2*NTAB*NENT; i++) begin
      tbl_len[i] = 0; tbl_code[i] = 0; tbl_sym[i] = 0;
    end
    for (int i = 0; i < NCOMP; i++) dc_pred[i] = 0;
    ph = PH_IDLE; bits_acc = 0; bit_cnt = 0; comp = 0; dc_sel = 0; ac_sel = 0;
    repeat (3) @(negedge clk);
    rst_n <= 1;
    test_directed();
    test_noise();
    test_blocks();
    test_backpressure();
    test_no_idle();
    if (expected_coefs.size() != 0) errors++;
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #200ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
